// File: design/sorted_set_insert_unit_defines.svh
// Assertion macros shared by the sorted set insert unit.
`ifndef SORTED_SET_INSERT_UNIT_DEFINES_SVH
`define SORTED_SET_INSERT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ssi_pkg.sv
// Package: sizes, status codes and payload types of the sorted set insert unit.
`timescale 1ns / 1ps
package ssi_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int RD_W     = 6;
    localparam int POS_W    = 6;
    localparam int STAT_W   = 3;
    localparam int CNTO_W   = 7;
    localparam int CMP_W    = (CNT_W > RD_W) ? CNT_W : RD_W;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_READ_OK  = 3'd3;
    localparam logic [STAT_W-1:0] ST_READ_OOB = 3'd4;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
        logic [RD_W-1:0]         read_index;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [POS_W-1:0]        position;
        logic signed [KEY_W-1:0] entry_key;
        logic [CNTO_W-1:0]       count_after;
    } t_out_item;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                    load;
        logic                    commit;
        logic signed [KEY_W-1:0] key;
        logic [RD_W-1:0]         read_index;
        logic [CNT_W-1:0]        count;
    } t_cell_cmd;

endpackage

// File: design/ssi_cell.sv
// One table cell: holds a key, registers its compare flags, shifts up on insert.
`timescale 1ns / 1ps
module ssi_cell import ssi_pkg::*; (
    input  logic                    i_clk,
    input  logic [IDX_W-1:0]        i_idx,
    input  t_cell_cmd               i_cmd,
    input  logic                    i_lt_prev,
    input  logic signed [KEY_W-1:0] i_key_prev,
    output logic                    o_lt,
    output logic                    o_eq,
    output logic signed [KEY_W-1:0] o_key,
    output logic signed [KEY_W-1:0] o_rd_key
);

    logic signed [KEY_W-1:0] r_key;
    logic                    r_lt;
    logic                    r_eq;
    logic                    r_sel;
    logic                    w_valid;

    assign w_valid = CNT_W'(i_idx) < i_cmd.count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lt  <= w_valid && (r_key < i_cmd.key);
            r_eq  <= w_valid && (r_key == i_cmd.key);
            r_sel <= CMP_W'(i_idx) == CMP_W'(i_cmd.read_index);
        end
        // Keep keys below the insert point, take the new key at it, shift the rest up.
        if (i_cmd.commit && !r_lt) begin
            r_key <= i_lt_prev ? i_cmd.key : i_key_prev;
        end
    end

    assign o_lt     = r_lt;
    assign o_eq     = r_eq;
    assign o_key    = r_key;
    assign o_rd_key = r_sel ? r_key : '0;

endmodule

// File: design/sorted_set_insert_unit.sv
// Top level: sorted set of distinct Q16.16 keys built as a chain of cells.
// Usage:
//   Input channel i_valid / o_ready / i_item carries one item: mode 0 inserts
//   key, mode 1 reads the entry at read_index. Output channel o_valid /
//   i_ready / o_item returns exactly one result per item: status, position,
//   entry_key and count_after.
//   Each item passes through a compare step and an evaluation step: in
//   the transfer cycle every cell compares its key with the new key and
//   registers its flags; in evaluation, once the result register is free,
//   the insert position is encoded from those flags, the result is
//   registered and, for a new key on a non-full table, all cells above the
//   position shift up by one at once. No item is taken during evaluation.
//   The result register sits between the sides, so a new item is taken
//   while an earlier result waits. If the receiver stalls, the second item
//   holds in evaluation until the result register frees up; o_ready stays
//   low meanwhile.
//   Reset empties the table (count to zero); stored keys are not cleared and
//   need no clearing pass, since only positions below the count are read.
`timescale 1ns / 1ps
`include "sorted_set_insert_unit_defines.svh"
module sorted_set_insert_unit import ssi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    t_in_item         r_in;
    t_out_item        r_out;
    t_out_item        w_res;
    t_cell_cmd        w_cmd;

    logic                    w_lt     [CAPACITY];
    logic                    w_eq     [CAPACITY];
    logic signed [KEY_W-1:0] w_key    [CAPACITY];
    logic signed [KEY_W-1:0] w_rd_key [CAPACITY];

    logic                    w_accept;
    logic                    w_fire;
    logic                    w_commit;
    logic                    w_hit;
    logic                    w_full;
    logic                    w_rd_ok;
    logic [CNT_W-1:0]        w_pos;
    logic signed [KEY_W-1:0] w_rd_val;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_fire   = (r_state == S_EVAL) && (!r_out_valid || i_ready);
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_rd_ok  = CMP_W'(r_in.read_index) < CMP_W'(r_count);
    assign w_commit = w_fire && (r_in.mode == MODE_INSERT) && !w_hit && !w_full;

    always_comb begin
        w_cmd.load       = w_accept;
        w_cmd.commit     = w_commit;
        w_cmd.key        = (r_state == S_IDLE) ? i_item.key : r_in.key;
        w_cmd.read_index = i_item.read_index;
        w_cmd.count      = r_count;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            ssi_cell u_cell (
                .i_clk      (i_clk),
                .i_idx      (IDX_W'(g)),
                .i_cmd      (w_cmd),
                .i_lt_prev  (1'b1),
                .i_key_prev (w_cmd.key),
                .o_lt       (w_lt[g]),
                .o_eq       (w_eq[g]),
                .o_key      (w_key[g]),
                .o_rd_key   (w_rd_key[g])
            );
        end else begin : g_body
            ssi_cell u_cell (
                .i_clk      (i_clk),
                .i_idx      (IDX_W'(g)),
                .i_cmd      (w_cmd),
                .i_lt_prev  (w_lt[g-1]),
                .i_key_prev (w_key[g-1]),
                .o_lt       (w_lt[g]),
                .o_eq       (w_eq[g]),
                .o_key      (w_key[g]),
                .o_rd_key   (w_rd_key[g])
            );
        end
    end

    // The less-than flags form a thermometer; its edge is the lower bound.
    always_comb begin
        w_pos    = '0;
        w_hit    = 1'b0;
        w_rd_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (((i == 0) || w_lt[(i == 0) ? 0 : i - 1]) && !w_lt[i]) begin
                w_pos = w_pos | CNT_W'(i);
            end
            w_hit    = w_hit | w_eq[i];
            w_rd_val = w_rd_val | w_rd_key[i];
        end
    end

    always_comb begin
        n_count = w_commit ? CNT_W'(r_count + 1'b1) : r_count;
        w_res.count_after = CNTO_W'(n_count);
        if (r_in.mode == MODE_INSERT) begin
            w_res.entry_key = r_in.key;
            if (w_hit) begin
                w_res.status   = ST_PRESENT;
                w_res.position = POS_W'(w_pos);
            end else if (w_full) begin
                w_res.status   = ST_FULL;
                w_res.position = '0;
            end else begin
                w_res.status   = ST_INSERTED;
                w_res.position = POS_W'(w_pos);
            end
        end else begin
            w_res.position = r_in.read_index;
            if (w_rd_ok) begin
                w_res.status    = ST_READ_OK;
                w_res.entry_key = w_rd_val;
            end else begin
                w_res.status    = ST_READ_OOB;
                w_res.entry_key = '0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EVAL;
            S_EVAL:  if (w_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_item;
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    `SSI_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `SSI_ASSERT_NEXT(a_accept_eval, w_accept, r_state == S_EVAL, "accepted item not evaluated")
    `SSI_ASSERT_NEXT(a_insert_count, w_commit, r_count == CNT_W'($past(r_count) + 1'b1), "insert did not grow count")
    `SSI_ASSERT_NOW(a_fire_slot, w_fire, !r_out_valid || i_ready, "result overwrote a pending one")

endmodule

// File: tb/sv/testbench.sv
// Testbench for sorted_set_insert_unit: directed and random inserts and reads, checked by a scoreboard.
`timescale 1ns / 1ps
module testbench;
    import ssi_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 227;
    localparam int TAIL_CYCLES  = 6;

    // Tracks the ordered key table and the results it should produce.
    class key_table_tracker;
        logic signed [KEY_W-1:0] keys [CAPACITY];
        int                      count;
        t_out_item               expected_q [$];
        int                      mismatches;
        int                      n_inserted, n_present, n_full, n_read_ok, n_read_oob;

        function void note_transfer_in(t_in_item it);
            t_out_item r;
            int        p;
            r.count_after = '0;
            if (it.mode == MODE_INSERT) begin
                p = 0;
                while (p < count && keys[p] < it.key) p++;
                r.entry_key = it.key;
                if (p < count && keys[p] == it.key) begin
                    r.status   = ST_PRESENT;
                    r.position = POS_W'(p);
                    n_present++;
                end else if (count >= CAPACITY) begin
                    r.status   = ST_FULL;
                    r.position = '0;
                    n_full++;
                end else begin
                    // open a gap at the sorted position
                    for (int i = count; i > p; i--) keys[i] = keys[i-1];
                    keys[p] = it.key;
                    count++;
                    r.status   = ST_INSERTED;
                    r.position = POS_W'(p);
                    n_inserted++;
                end
            end else begin
                r.position = it.read_index;
                if (int'(it.read_index) < count) begin
                    r.status    = ST_READ_OK;
                    r.entry_key = keys[it.read_index];
                    n_read_ok++;
                end else begin
                    r.status    = ST_READ_OOB;
                    r.entry_key = '0;
                    n_read_oob++;
                end
            end
            r.count_after = CNTO_W'(count);
            expected_q.push_back(r);
        endfunction

        function void log_mismatch(string what, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH (%s): expected status=%0d pos=%0d key=%h count=%0d, got status=%0d pos=%0d key=%h count=%0d",
                         what, want.status, want.position, want.entry_key, want.count_after,
                         got.status, got.position, got.entry_key, got.count_after);
        endfunction

        function void check_transfer_out(t_out_item got);
            t_out_item want;
            want = '0;
            if (expected_q.size() == 0) begin
                log_mismatch("unexpected result", want, got);
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status || got.position !== want.position ||
                    got.entry_key !== want.entry_key || got.count_after !== want.count_after)
                    log_mismatch("field", want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_item;

    key_table_tracker sb = new();

    int send_gap_pct   = 29;
    int take_stall_pct = 60;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    int cycle_cnt      = 0;

    sorted_set_insert_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= take_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_transfer_in(i_item);
            if (o_valid && i_ready) sb.check_transfer_out(o_item);
        end
    end

    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic t_in_item insert_op(logic signed [KEY_W-1:0] k);
        t_in_item it;
        it.mode       = MODE_INSERT;
        it.key        = k;
        it.read_index = RD_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item read_op(int idx);
        t_in_item it;
        it.mode       = MODE_READ;
        it.key        = $urandom;
        it.read_index = RD_W'(idx);
        return it;
    endfunction

    // New key: near an existing one, small, or fully random.
    function automatic logic signed [KEY_W-1:0] fresh_key();
        int                      sel;
        logic signed [KEY_W-1:0] k;
        sel = $urandom_range(0, 9);
        if (sb.count > 0 && sel < 3) begin
            k = sb.keys[$urandom_range(0, sb.count - 1)];
            k = ($urandom_range(0, 1) != 0) ? k + 1 : k - 1;
        end else if (sel < 5) begin
            k = KEY_W'($signed($urandom_range(0, 64)) - 32);
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    function automatic t_in_item next_random_item();
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            if (sb.count > 0 && $urandom_range(0, 3) != 0)
                idx = $urandom_range(0, sb.count - 1);
            else
                idx = $urandom_range(0, 63);
            return read_op(idx);
        end else if (r < 80 && sb.count > 0) begin
            return insert_op(sb.keys[$urandom_range(0, sb.count - 1)]);
        end
        return insert_op(fresh_key());
    endfunction

    // Offer one item and hold it until the transfer.
    task automatic send_item(t_in_item it);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        while (sb.pending() > 0) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic run_random(int n);
        repeat (n) send_item(next_random_item());
        drain_results();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table reads, then extremes, duplicates and reads back
        send_item(read_op(0));
        send_item(read_op(63));
        send_item(insert_op(32'sh0000_0000));
        send_item(insert_op(32'sh0000_0000));
        send_item(insert_op(32'sh7FFF_FFFF));
        send_item(insert_op(32'sh8000_0000));
        send_item(insert_op(32'shFFFF_FFFF));
        send_item(insert_op(32'sh0000_0001));
        send_item(insert_op(32'sh0001_0000));
        send_item(insert_op(32'shFFFF_0000));
        send_item(insert_op(32'sh7FFF_FFFE));
        send_item(insert_op(32'sh8000_0001));
        send_item(insert_op(32'sh8000_0000));
        send_item(insert_op(32'sh7FFF_FFFF));
        send_item(read_op(0));
        send_item(read_op(4));
        send_item(read_op(8));
        send_item(read_op(9));
        send_item(read_op(63));
        drain_results();

        run_random(PHASE_ITEMS);

        send_gap_pct   = 60;
        take_stall_pct = 29;
        run_random(PHASE_ITEMS);

        // no idling; receiver holds off for a while so the block backs up
        send_gap_pct   = 0;
        take_stall_pct = 0;
        hold_request   = 1'b1;
        run_random(PHASE_ITEMS);

        i_valid <= 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("inserts: %0d stored, %0d already present, %0d refused on a full table",
                 sb.n_inserted, sb.n_present, sb.n_full);
        $display("reads: %0d in range, %0d beyond count; %0d keys held at the end",
                 sb.n_read_ok, sb.n_read_oob, sb.count);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sorted_set_insert_unit.f
+incdir+design
design/ssi_pkg.sv
design/ssi_cell.sv
design/sorted_set_insert_unit.sv
tb/sv/testbench.sv
